[rtl/gtpuhb_pkg.sv]
package gtpuhb_pkg;

    localparam int unsigned HDR_BYTES = 58;
    localparam int unsigned IDX_W     = $clog2(HDR_BYTES);
    localparam logic [IDX_W-1:0] HDR_LAST_IDX = IDX_W'(HDR_BYTES - 1);

    localparam int unsigned CFG_DATA_W  = 48;
    localparam int unsigned CFG_INDEX_W = 2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_MAC       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DESTINATION_MAC  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_IPV4      = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DESTINATION_IPV4 = 2'd3;

    // fixed header values
    localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  IP_VER_IHL      = 8'h45;
    localparam logic [7:0]  IP_TTL          = 8'd64;
    localparam logic [7:0]  IP_PROTO_UDP    = 8'd17;
    localparam logic [15:0] UDP_SRC_PORT    = 16'd12345;
    localparam logic [15:0] UDP_DST_PORT    = 16'd2152;
    localparam logic [7:0]  GTP_FLAGS       = 8'h34;
    localparam logic [7:0]  GTP_MSG_GPDU    = 8'hFF;
    localparam logic [7:0]  EXT_PDU_SESSION = 8'h85;
    localparam logic [7:0]  EXT_LEN_WORDS   = 8'h01;
    localparam logic [7:0]  EXT_PDU_TYPE    = 8'h10;
    localparam logic [7:0]  EXT_NEXT_NONE   = 8'h00;
    localparam logic [15:0] IP_LEN_ADD      = 16'd44;
    localparam logic [15:0] UDP_LEN_ADD     = 16'd24;
    localparam logic [15:0] GTP_LEN_ADD     = 16'd8;

    // sum of the constant ipv4 header words: version/ihl and ttl/protocol
    localparam logic [15:0] IP_CONST_SUM = {IP_VER_IHL, 8'h00} + {IP_TTL, IP_PROTO_UDP};

    typedef struct packed {
        logic [47:0] source_mac;
        logic [47:0] destination_mac;
        logic [31:0] source_ipv4;
        logic [31:0] destination_ipv4;
    } cfg_t;

    typedef struct packed {
        logic [31:0] tunnel_id;
        logic [5:0]  flow_id;
        logic [15:0] ip_length;
        logic [15:0] udp_length;
        logic [15:0] gtp_length;
        logic [15:0] checksum;
    } work_t;

    function automatic logic [15:0] ip_checksum(input cfg_t cfg, input logic [15:0] ip_length);
        logic [18:0] sum;
        logic [16:0] fold;
        logic [15:0] folded;
        sum = 19'(IP_CONST_SUM) + 19'(ip_length)
            + 19'(cfg.source_ipv4[31:16]) + 19'(cfg.source_ipv4[15:0])
            + 19'(cfg.destination_ipv4[31:16]) + 19'(cfg.destination_ipv4[15:0]);
        fold = 17'(sum[18:16]) + 17'(sum[15:0]);
        folded = fold[15:0] + 16'(fold[16]);
        return ~folded;
    endfunction

    function automatic logic [7:0] header_byte_at(input logic [IDX_W-1:0] idx,
                                                  input cfg_t cfg, input work_t w);
        logic [7:0] b;
        b = 8'h00;
        unique case (idx)
            6'd0:  b = cfg.destination_mac[47:40];
            6'd1:  b = cfg.destination_mac[39:32];
            6'd2:  b = cfg.destination_mac[31:24];
            6'd3:  b = cfg.destination_mac[23:16];
            6'd4:  b = cfg.destination_mac[15:8];
            6'd5:  b = cfg.destination_mac[7:0];
            6'd6:  b = cfg.source_mac[47:40];
            6'd7:  b = cfg.source_mac[39:32];
            6'd8:  b = cfg.source_mac[31:24];
            6'd9:  b = cfg.source_mac[23:16];
            6'd10: b = cfg.source_mac[15:8];
            6'd11: b = cfg.source_mac[7:0];
            6'd12: b = ETHERTYPE_IPV4[15:8];
            6'd13: b = ETHERTYPE_IPV4[7:0];
            6'd14: b = IP_VER_IHL;
            6'd16: b = w.ip_length[15:8];
            6'd17: b = w.ip_length[7:0];
            6'd22: b = IP_TTL;
            6'd23: b = IP_PROTO_UDP;
            6'd24: b = w.checksum[15:8];
            6'd25: b = w.checksum[7:0];
            6'd26: b = cfg.source_ipv4[31:24];
            6'd27: b = cfg.source_ipv4[23:16];
            6'd28: b = cfg.source_ipv4[15:8];
            6'd29: b = cfg.source_ipv4[7:0];
            6'd30: b = cfg.destination_ipv4[31:24];
            6'd31: b = cfg.destination_ipv4[23:16];
            6'd32: b = cfg.destination_ipv4[15:8];
            6'd33: b = cfg.destination_ipv4[7:0];
            6'd34: b = UDP_SRC_PORT[15:8];
            6'd35: b = UDP_SRC_PORT[7:0];
            6'd36: b = UDP_DST_PORT[15:8];
            6'd37: b = UDP_DST_PORT[7:0];
            6'd38: b = w.udp_length[15:8];
            6'd39: b = w.udp_length[7:0];
            6'd42: b = GTP_FLAGS;
            6'd43: b = GTP_MSG_GPDU;
            6'd44: b = w.gtp_length[15:8];
            6'd45: b = w.gtp_length[7:0];
            6'd46: b = w.tunnel_id[31:24];
            6'd47: b = w.tunnel_id[23:16];
            6'd48: b = w.tunnel_id[15:8];
            6'd49: b = w.tunnel_id[7:0];
            6'd53: b = EXT_PDU_SESSION;
            6'd54: b = EXT_LEN_WORDS;
            6'd55: b = EXT_PDU_TYPE;
            6'd56: b = {2'b00, w.flow_id};
            6'd57: b = EXT_NEXT_NONE;
            // zero fields: tos, id, fragment, udp checksum, gtp padding
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[rtl/gtpu_encapsulation_header_builder_unit.sv]
// GTP-U outer header builder. Each request transaction (tunnel_id, flow_id,
// inner_length) produces 58 result transactions, one header byte each, in wire
// order: Ethernet (configured MACs, ethertype IPv4), IPv4 (ttl 64, UDP, lengths,
// ones-complement header checksum), UDP (12345 -> 2152, checksum 0) and GTP-U
// with a PDU session container carrying flow_id; last_byte marks byte 58.
// The byte-wide result channel sets the pace: the output register moves one
// byte per cycle while out_ready holds. A request buffer stage in front of the
// byte serializer takes the next request while the current header is still
// streaming, so headers follow each other with no gap when out_ready stays high.
// Configuration writes (cfg_write_enable, cfg_index, cfg_data) take effect at
// the clock edge and must only be made while no header is in flight.
module gtpu_encapsulation_header_builder_unit
    import gtpuhb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_write_enable,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [31:0]            tunnel_id,
    input  logic [5:0]             flow_id,
    input  logic [10:0]            inner_length,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             header_byte,
    output logic                   last_byte
);

    // configuration registers
    cfg_t cfg_reg;

    // request buffer stage
    logic        req_valid_reg;
    logic [31:0] req_tunnel_id_reg;
    logic [5:0]  req_flow_id_reg;
    logic [10:0] req_inner_length_reg;

    // serializer stage
    logic             work_valid_reg;
    work_t            work_reg;
    work_t            work_next;
    logic [IDX_W-1:0] byte_idx_reg;

    // output register
    logic       out_valid_reg;
    logic [7:0] header_byte_reg;
    logic       last_byte_reg;

    logic in_accept;
    logic out_advance;
    logic load_out;
    logic work_done;
    logic transfer;

    // handshake and stage control
    assign out_advance = !out_valid_reg || out_ready;
    assign load_out    = work_valid_reg && out_advance;
    assign work_done   = load_out && (byte_idx_reg == HDR_LAST_IDX);
    // buffered request moves in as the current header hands over its last byte
    assign transfer    = req_valid_reg && (!work_valid_reg || work_done);
    assign in_ready    = !req_valid_reg || transfer;
    assign in_accept   = in_valid && in_ready;

    assign out_valid   = out_valid_reg;
    assign header_byte = header_byte_reg;
    assign last_byte   = last_byte_reg;

    // length fields and checksum are fixed per request when it enters the serializer
    always_comb
    begin
        work_next.tunnel_id  = req_tunnel_id_reg;
        work_next.flow_id    = req_flow_id_reg;
        work_next.ip_length  = 16'(req_inner_length_reg) + IP_LEN_ADD;
        work_next.udp_length = 16'(req_inner_length_reg) + UDP_LEN_ADD;
        work_next.gtp_length = 16'(req_inner_length_reg) + GTP_LEN_ADD;
        work_next.checksum   = ip_checksum(cfg_reg, work_next.ip_length);
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                REG_SOURCE_MAC:       cfg_reg.source_mac       <= cfg_data;
                REG_DESTINATION_MAC:  cfg_reg.destination_mac  <= cfg_data;
                REG_SOURCE_IPV4:      cfg_reg.source_ipv4      <= cfg_data[31:0];
                REG_DESTINATION_IPV4: cfg_reg.destination_ipv4 <= cfg_data[31:0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg  <= 1'b0;
            work_valid_reg <= 1'b0;
            byte_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept)
                req_valid_reg <= 1'b1;
            else if (transfer)
                req_valid_reg <= 1'b0;

            if (transfer)
            begin
                work_valid_reg <= 1'b1;
                byte_idx_reg   <= '0;
            end
            else if (work_done)
            begin
                work_valid_reg <= 1'b0;
                byte_idx_reg   <= '0;
            end
            else if (load_out)
            begin
                byte_idx_reg <= byte_idx_reg + 1'b1;
            end

            if (out_advance)
                out_valid_reg <= load_out;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_tunnel_id_reg    <= tunnel_id;
            req_flow_id_reg      <= flow_id;
            req_inner_length_reg <= inner_length;
        end

        if (transfer)
            work_reg <= work_next;

        if (load_out)
        begin
            header_byte_reg <= header_byte_at(byte_idx_reg, cfg_reg, work_reg);
            last_byte_reg   <= (byte_idx_reg == HDR_LAST_IDX);
        end
    end

    // a request entering the serializer always starts at the first header byte
    a_transfer_starts: assert property (@(posedge clk) disable iff (!rst_n)
        transfer |=> (work_valid_reg && (byte_idx_reg == '0)))
        else $error("serializer did not restart at byte zero");

    // byte counter never runs past the last header byte
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        work_valid_reg |-> (byte_idx_reg <= HDR_LAST_IDX))
        else $error("byte index beyond header length");

    // input stalls only while both the buffer and the serializer are occupied
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (req_valid_reg && work_valid_reg))
        else $error("input stalled with a free stage");

    // the final byte of a header leaves the serializer idle unless a request waits
    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        (work_done && !req_valid_reg) |=> !work_valid_reg)
        else $error("serializer busy after last byte");

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench
    import gtpuhb_pkg::*;
;

    // cycles without any transaction before the run is declared hung
    localparam int unsigned QUIET_LIMIT = 4000;
    // cap on printed mismatch lines
    localparam int unsigned REPORT_CAP  = 40;

    // one expected header byte as it should appear on the result channel
    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } header_octet_t;

    // one request transaction
    typedef struct packed {
        logic [31:0] tid;
        logic [5:0]  fid;
        logic [10:0] ilen;
    } gtp_request_t;

    // predicts the outer header of every accepted request and checks
    // the byte stream against it in order
    class header_scoreboard;
        logic [47:0]   src_mac;
        logic [47:0]   dst_mac;
        logic [31:0]   src_ip;
        logic [31:0]   dst_ip;
        header_octet_t pending[$];
        int unsigned   errors;
        int unsigned   requests;
        int unsigned   bytes_checked;

        function new();
            src_mac       = '0;
            dst_mac       = '0;
            src_ip        = '0;
            dst_ip        = '0;
            errors        = 0;
            requests      = 0;
            bytes_checked = 0;
        endfunction

        function void set_reg(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SOURCE_MAC:       src_mac = data[47:0];
                REG_DESTINATION_MAC:  dst_mac = data[47:0];
                REG_SOURCE_IPV4:      src_ip  = data[31:0];
                REG_DESTINATION_IPV4: dst_ip  = data[31:0];
                default: ;
            endcase
        endfunction

        function void note_request(input logic [31:0] tid, input logic [5:0] fid,
                                   input logic [10:0] ilen);
            logic [7:0]    hdr [58];
            logic [15:0]   ip_len;
            logic [15:0]   udp_len;
            logic [15:0]   gtp_len;
            logic [15:0]   csum;
            logic [31:0]   acc;
            header_octet_t octet;
            for (int k = 0; k < 58; k++)
                hdr[k] = 8'h00;
            ip_len  = 16'(ilen) + 16'd44;
            udp_len = 16'(ilen) + 16'd24;
            gtp_len = 16'(ilen) + 16'd8;
            // ethernet
            for (int k = 0; k < 6; k++)
            begin
                hdr[k]     = dst_mac[47 - 8 * k -: 8];
                hdr[6 + k] = src_mac[47 - 8 * k -: 8];
            end
            hdr[12] = 8'h08;
            hdr[13] = 8'h00;
            // ipv4, checksum field left zero until summed
            hdr[14] = 8'h45;
            hdr[16] = ip_len[15:8];
            hdr[17] = ip_len[7:0];
            hdr[22] = 8'd64;
            hdr[23] = 8'd17;
            for (int k = 0; k < 4; k++)
            begin
                hdr[26 + k] = src_ip[31 - 8 * k -: 8];
                hdr[30 + k] = dst_ip[31 - 8 * k -: 8];
            end
            acc = '0;
            for (int k = 14; k < 34; k += 2)
                acc += {16'h0000, hdr[k], hdr[k + 1]};
            acc = (acc >> 16) + (acc & 32'h0000_ffff);
            acc = acc + (acc >> 16);
            csum = ~acc[15:0];
            hdr[24] = csum[15:8];
            hdr[25] = csum[7:0];
            // udp
            hdr[34] = 8'h30;
            hdr[35] = 8'h39;
            hdr[36] = 8'h08;
            hdr[37] = 8'h68;
            hdr[38] = udp_len[15:8];
            hdr[39] = udp_len[7:0];
            // gtp-u with pdu session container
            hdr[42] = 8'h34;
            hdr[43] = 8'hff;
            hdr[44] = gtp_len[15:8];
            hdr[45] = gtp_len[7:0];
            for (int k = 0; k < 4; k++)
                hdr[46 + k] = tid[31 - 8 * k -: 8];
            hdr[53] = 8'h85;
            hdr[54] = 8'h01;
            hdr[55] = 8'h10;
            hdr[56] = {2'b00, fid};
            hdr[57] = 8'h00;
            for (int k = 0; k < 58; k++)
            begin
                octet.value = hdr[k];
                octet.last  = (k == 57);
                pending.push_back(octet);
            end
            requests++;
        endfunction

        function void check_byte(input logic [7:0] value, input logic last);
            header_octet_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: unexpected byte %02h last %0b", $time, value, last);
                return;
            end
            want = pending.pop_front();
            bytes_checked++;
            if (value !== want.value)
            begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: header_byte expected %02h actual %02h",
                             $time, want.value, value);
            end
            if (last !== want.last)
            begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: last_byte expected %0b actual %0b",
                             $time, want.last, last);
            end
        endfunction
    endclass

    // clock, reset and block inputs, all known from time zero
    logic                   clk              = 1'b0;
    logic                   rst_n            = 1'b0;
    logic                   cfg_write_enable = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index        = '0;
    logic [CFG_DATA_W-1:0]  cfg_data         = '0;
    logic                   in_valid         = 1'b0;
    logic [31:0]            tunnel_id        = '0;
    logic [5:0]             flow_id          = '0;
    logic [10:0]            inner_length     = '0;
    logic                   out_ready        = 1'b0;

    // block outputs
    logic                   in_ready;
    logic                   out_valid;
    logic [7:0]             header_byte;
    logic                   last_byte;

    // idling knobs, percent per decision
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    // long receiver hold-off, picked up by the receiver process
    int unsigned hold_request  = 0;

    int unsigned quiet_cycles  = 0;
    int unsigned settings_used = 1;

    header_scoreboard sb = new();

    gtp_request_t corner_requests [12];

    gtpu_encapsulation_header_builder_unit DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .tunnel_id        (tunnel_id),
        .flow_id          (flow_id),
        .inner_length     (inner_length),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .header_byte      (header_byte),
        .last_byte        (last_byte)
    );

    // 8 ns clock
    initial
    begin
        forever
            #4 clk = ~clk;
    end

    // transaction monitor: values read at the edge are the pre-edge values,
    // since every driver here updates with nonblocking assignments
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            sb.note_request(tunnel_id, flow_id, inner_length);
        if (out_valid && out_ready)
            sb.check_byte(header_byte, last_byte);
    end

    // hang detection: any transaction or register write resets the count
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write_enable)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // one register write; enable is left high so back-to-back writes
    // never lower and raise it in the same step
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write_enable <= 1'b1;
        cfg_index        <= idx;
        cfg_data         <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    // full register set; the ipv4 words may carry junk above bit 31
    task automatic write_config(input logic [47:0] smac, input logic [47:0] dmac,
                                input logic [47:0] sip, input logic [47:0] dip);
        write_reg(REG_SOURCE_MAC, smac);
        write_reg(REG_DESTINATION_MAC, dmac);
        write_reg(REG_SOURCE_IPV4, sip);
        write_reg(REG_DESTINATION_IPV4, dip);
        cfg_write_enable <= 1'b0;
        settings_used++;
    endtask

    // offer one request, optionally after an idle gap, and wait for acceptance;
    // valid stays high on return so the next request can follow directly
    task automatic send_request(input logic [31:0] tid, input logic [5:0] fid,
                                input logic [10:0] ilen);
        int unsigned gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct)
            gap = $urandom_range(150, 1);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        tunnel_id    <= tid;
        flow_id      <= fid;
        inner_length <= ilen;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_random(input int unsigned count);
        logic [10:0] ilen;
        for (int n = 0; n < count; n++)
        begin
            // lengths past the nominal maximum now and then
            if ($urandom_range(9) == 0)
                ilen = 11'($urandom_range(2047, 1457));
            else
                ilen = 11'($urandom_range(1456));
            send_request($urandom, 6'($urandom_range(63)), ilen);
        end
    endtask

    // stop offering and wait until every expected byte has come out;
    // it first waits for an edge so the monitor has logged the last accepted request
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic send_corners();
        for (int n = 0; n < 12; n++)
            send_request(corner_requests[n].tid, corner_requests[n].fid,
                         corner_requests[n].ilen);
    endtask

    initial
    begin
        // extremes of every field, lengths at and beyond the nominal range
        corner_requests = '{
            '{32'h0000_0000, 6'd0,  11'd0},
            '{32'hffff_ffff, 6'd63, 11'd1456},
            '{32'hffff_ffff, 6'd63, 11'd2047},
            '{32'h1234_5678, 6'd21, 11'd100},
            '{32'ha5a5_a5a5, 6'd42, 11'd1024},
            '{32'h5a5a_5a5a, 6'd21, 11'd1023},
            '{32'h0000_0000, 6'd63, 11'd1},
            '{32'h8000_0001, 6'd1,  11'd1457},
            '{32'h0000_0001, 6'd32, 11'd1455},
            '{32'hdead_beef, 6'h2a, 11'h555},
            '{32'h0f0f_0f0f, 6'h15, 11'h2aa},
            '{32'hfedc_ba98, 6'h3f, 11'd64}
        };

        // reset held, then released at an edge
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // corner requests with the reset register values, no idling
        send_corners();
        drain();

        // same requests with every register bit set: checksum carries fold
        write_config({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}});
        send_corners();
        drain();

        // random requests, no idling
        write_config(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                     48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
        send_random(34);
        drain();

        // sender mostly idle, alternating register patterns
        send_idle_pct = 80;
        stall_pct     = 0;
        write_config(48'haaaa_aaaa_aaaa, 48'h5555_5555_5555,
                     48'h5555_aaaa_aaaa, 48'haaaa_5555_5555);
        send_random(34);
        drain();

        // receiver mostly stalling
        send_idle_pct = 0;
        stall_pct     = 80;
        write_config(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                     {16'h0000, $urandom}, {16'hffff, $urandom});
        send_random(34);
        drain();

        // both sides idling now and then
        send_idle_pct = 32;
        stall_pct     = 32;
        write_config(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                     48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
        send_random(34);
        drain();

        // back pressure: receiver holds off while requests keep coming,
        // so the request buffer fills and in_ready drops
        send_idle_pct = 0;
        stall_pct     = 0;
        write_config('0, '0, '0, '0);
        hold_request = 400;
        send_random(10);
        drain();

        // let any stray bytes show up before the verdict
        repeat (64) @(posedge clk);
        if (sb.pending.size() != 0)
        begin
            $display("%0t: %0d header bytes never arrived", $time, sb.pending.size());
            sb.errors++;
        end

        $display("run covered %0d requests and %0d header bytes under %0d register settings",
                 sb.requests, sb.bytes_checked, settings_used);
        $display("idling phases: none, sender, receiver, both, and a long receiver hold-off");
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/gtpuhb_pkg.sv
rtl/gtpu_encapsulation_header_builder_unit.sv
sim/testbench.sv
